[design/fpsched_pkg.sv]
// ----------------------------------------------------------------------------
// fpsched_pkg
// Shared types and constants of the fixed-priority round-robin scheduler:
// request and result items, request modes, status codes, thread flag bits,
// controller states and the command/status link between controller and
// datapath.
// ----------------------------------------------------------------------------
package fpsched_pkg;

    // request item as it arrives on the input channel
    typedef struct packed {
        logic [3:0]  mode;
        logic [5:0]  thread_id;
        logic [4:0]  priority_req;
        logic [5:0]  current_thread;
        logic [15:0] timeout_ticks;
    } t_in_item;

    // result item as it leaves on the output channel
    typedef struct packed {
        logic [5:0] next_thread;
        logic       do_switch;
        logic [1:0] status;
        logic       wake_early;
    } t_out_item;

    // request modes
    typedef enum logic [3:0] {
        MODE_ADD     = 4'd0,
        MODE_SETPRIO = 4'd1,
        MODE_BLOCK   = 4'd2,
        MODE_WAKE    = 4'd3,
        MODE_YIELD   = 4'd4,
        MODE_TICK    = 4'd5,
        MODE_SUSPEND = 4'd6,
        MODE_RESUME  = 4'd7,
        MODE_TIMEOUT = 4'd8,
        MODE_ACT     = 4'd9,
        MODE_DEACT   = 4'd10
    } t_mode;

    // result status codes
    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_EMPTY   = 2'd1;
    localparam logic [1:0] STS_INVALID = 2'd2;

    // thread flag bit positions
    localparam int FB_READY   = 0;
    localparam int FB_BLOCKED = 1;
    localparam int FB_SUSP    = 2;
    localparam int FB_EVENT   = 3;

    // wake count limits
    localparam logic [1:0] WAKE_MAX  = 2'd3;
    localparam logic [1:0] WAKE_INIT = 2'd1;

    // configuration registers
    localparam int         CFG_DATA_W         = 6;
    localparam logic [0:0] CFG_TIMEOUT_THREAD = 1'b0;
    localparam logic [0:0] CFG_TIMEOUT_ENABLE = 1'b1;

    // datapath commands
    typedef enum logic [4:0] {
        CMD_NOP,
        CMD_CLEAR,
        CMD_LATCH,
        CMD_RD_INFO,
        CMD_EVAL,
        CMD_EVAL_MOVE,
        CMD_REMOVE,
        CMD_APP_RD,
        CMD_APP_WR,
        CMD_APP_NX,
        CMD_SC_INIT_H,
        CMD_SA_RD,
        CMD_SA_INIT,
        CMD_SC_STEP,
        CMD_SC_HEAD,
        CMD_SC_CHK,
        CMD_TAKE,
        CMD_TGT,
        CMD_OUT_LOAD
    } t_cmd;

    // controller states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_INFO,
        ST_EVAL,
        ST_REMOVE,
        ST_APP_RD,
        ST_APP_WR,
        ST_APP_NX,
        ST_OP_DONE,
        ST_SA_RD,
        ST_SA_INIT,
        ST_SC_STEP,
        ST_SC_HEAD,
        ST_SC_CHK,
        ST_SC_END,
        ST_DONE
    } t_state;

    // which part of a request the sequencer is working on
    typedef enum logic [2:0] {
        PH_MAIN,
        PH_H1,
        PH_S1,
        PH_MOVE,
        PH_FIN,
        PH_S2
    } t_phase;

    typedef struct packed {
        t_cmd cmd;
    } t_dp_cmd;

    typedef struct packed {
        logic       clr_done;
        logic [3:0] mode;
        logic       rem;
        logic       app;
        logic       c_none;
        logic       lv_end;
        logic       rd_susp;
        logic       found_none;
        logic       found_cur;
        logic       out_free;
    } t_dp_status;

endpackage

[design/fpsched_dp.sv]
// ----------------------------------------------------------------------------
// fpsched_dp
// Scheduler datapath: per-thread memories (level, flags, wake count, list
// links), per-level head/tail memories, tick and deadline registers, request
// evaluation, list edits, scan registers and the output register.
// ----------------------------------------------------------------------------
module fpsched_dp
    import fpsched_pkg::*;
#(
    parameter int THREADS = 64,
    parameter int LEVELS  = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_in_item              i_in_data,
    input  logic                  i_out_stall,
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_st,
    output logic                  o_out_valid,
    output t_out_item             o_out_data
);

    localparam int TW   = $clog2(THREADS);
    localparam int LW   = $clog2(THREADS + 1);
    localparam int VW   = $clog2(LEVELS);
    localparam int LVW  = $clog2(LEVELS + 1);
    localparam int MAXD = (THREADS > LEVELS) ? THREADS : LEVELS;
    localparam int CW   = $clog2(MAXD);
    localparam logic [LW-1:0] NONE = LW'(THREADS);

    // memories
    logic [VW-1:0] lvl_mem  [THREADS];
    logic [3:0]    flg_mem  [THREADS];
    logic [1:0]    wk_mem   [THREADS];
    logic [LW-1:0] nxt_mem  [THREADS];
    logic [LW-1:0] prv_mem  [THREADS];
    logic [LW-1:0] head_mem [LEVELS];
    logic [LW-1:0] tail_mem [LEVELS];

    // registered read data
    logic [VW-1:0] r_lvl_rd;
    logic [3:0]    r_flg_rd;
    logic [1:0]    r_wk_rd;
    logic [LW-1:0] r_nxt_rd;
    logic [LW-1:0] r_prv_rd;
    logic [LW-1:0] r_head_rd;
    logic [LW-1:0] r_tail_rd;

    // working registers
    t_in_item        r_req;
    logic [TW-1:0]   r_t;
    logic [31:0]     r_tick;
    logic [31:0]     r_dl;
    logic [5:0]      r_tt;
    logic            r_ten;
    logic [CW-1:0]   r_clr;
    logic [LW-1:0]   r_p;
    logic [LW-1:0]   r_n;
    logic [VW-1:0]   r_ol;
    logic [VW-1:0]   r_nl;
    logic            r_rem;
    logic            r_app;
    logic            r_inv;
    logic            r_early;
    logic [LW-1:0]   r_c;
    logic [LVW-1:0]  r_lv;
    logic [LW-1:0]   r_found;
    logic [LW-1:0]   r_nx;
    logic            r_ov;
    t_out_item       r_out;
    t_out_item       n_out;

    // memory port controls
    logic            info_we;
    logic [TW-1:0]   info_wa;
    logic [VW-1:0]   lvl_wd;
    logic [3:0]      flg_wd;
    logic [1:0]      wk_wd;
    logic            nxt_we;
    logic [TW-1:0]   nxt_wa;
    logic [LW-1:0]   nxt_wd;
    logic            prv_we;
    logic [TW-1:0]   prv_wa;
    logic [LW-1:0]   prv_wd;
    logic            head_we;
    logic [VW-1:0]   head_wa;
    logic [LW-1:0]   head_wd;
    logic            tail_we;
    logic [VW-1:0]   tail_wa;
    logic [LW-1:0]   tail_wd;
    logic [TW-1:0]   info_ra;
    logic [VW-1:0]   lv_ra;

    // request evaluation results
    logic            p_inv;
    logic            p_wr;
    logic [VW-1:0]   p_lvl;
    logic [3:0]      p_flg;
    logic [1:0]      p_wk;
    logic            p_rem;
    logic            p_app;
    logic [VW-1:0]   p_nl;
    logic            p_early;
    logic            p_dl_we;
    logic [31:0]     p_dl;

    logic            t_ok;
    logic            c_ok;
    logic            l_ok;
    logic            tt_ok;
    logic            pres;
    logic [1:0]      w_dec;
    logic [1:0]      w_inc;
    logic [31:0]     abs_dl;
    logic            fire;

    // request checks on the latched item and the thread record just read
    assign t_ok   = 32'(r_req.thread_id) < THREADS;
    assign c_ok   = 32'(r_req.current_thread) < THREADS;
    assign l_ok   = 32'(r_req.priority_req) < LEVELS;
    assign tt_ok  = 32'(r_tt) < THREADS;
    assign pres   = r_flg_rd[FB_READY] | r_flg_rd[FB_BLOCKED] | r_flg_rd[FB_EVENT];
    assign w_dec  = (r_wk_rd != 2'd0) ? r_wk_rd - 2'd1 : 2'd0;
    assign w_inc  = (r_wk_rd != WAKE_MAX) ? r_wk_rd + 2'd1 : WAKE_MAX;
    assign abs_dl = r_tick + 32'(r_req.timeout_ticks);
    assign fire   = r_ten && (r_dl != 32'd0) && (r_tick == r_dl);

    // per-mode plan: record update, unlink, relink, early wake, deadline
    always_comb begin
        p_inv   = 1'b0;
        p_wr    = 1'b0;
        p_lvl   = r_lvl_rd;
        p_flg   = r_flg_rd;
        p_wk    = r_wk_rd;
        p_rem   = 1'b0;
        p_app   = 1'b0;
        p_nl    = r_lvl_rd;
        p_early = 1'b0;
        p_dl_we = 1'b0;
        p_dl    = r_dl;
        case (r_req.mode)
            MODE_ADD: begin
                if (!t_ok || !l_ok || pres) begin
                    p_inv = 1'b1;
                end else begin
                    p_wr  = 1'b1;
                    p_lvl = VW'(r_req.priority_req);
                    p_flg = 4'b0001 << FB_READY;
                    p_wk  = WAKE_INIT;
                    p_app = 1'b1;
                    p_nl  = VW'(r_req.priority_req);
                end
            end
            MODE_SETPRIO: begin
                if (!t_ok || !l_ok || !pres) begin
                    p_inv = 1'b1;
                end else begin
                    p_wr  = 1'b1;
                    p_lvl = VW'(r_req.priority_req);
                    p_nl  = VW'(r_req.priority_req);
                    p_rem = r_flg_rd[FB_READY];
                    p_app = r_flg_rd[FB_READY];
                end
            end
            MODE_BLOCK: begin
                if (!c_ok || !r_flg_rd[FB_READY]) begin
                    p_inv = 1'b1;
                end else begin
                    p_wr = 1'b1;
                    p_wk = w_dec;
                    if (w_dec != 2'd0) begin
                        p_early = 1'b1;
                    end else begin
                        p_flg[FB_READY]   = 1'b0;
                        p_flg[FB_BLOCKED] = 1'b1;
                        p_rem             = 1'b1;
                    end
                end
            end
            MODE_WAKE: begin
                if (!t_ok || !pres) begin
                    p_inv = 1'b1;
                end else begin
                    p_wr = 1'b1;
                    p_wk = w_inc;
                    if (r_flg_rd[FB_BLOCKED]) begin
                        p_flg[FB_READY]   = 1'b1;
                        p_flg[FB_BLOCKED] = 1'b0;
                        p_app             = 1'b1;
                    end
                end
            end
            MODE_YIELD: begin
            end
            MODE_TICK: begin
                if (fire) begin
                    p_dl_we = 1'b1;
                    p_dl    = 32'd0;
                    if (tt_ok && pres) begin
                        p_wr = 1'b1;
                        p_wk = w_inc;
                        if (r_flg_rd[FB_BLOCKED]) begin
                            p_flg[FB_READY]   = 1'b1;
                            p_flg[FB_BLOCKED] = 1'b0;
                            p_app             = 1'b1;
                        end
                    end
                end
            end
            MODE_SUSPEND: begin
                if (!t_ok || !pres) begin
                    p_inv = 1'b1;
                end else begin
                    p_wr             = 1'b1;
                    p_flg[FB_SUSP]   = 1'b1;
                end
            end
            MODE_RESUME: begin
                if (!t_ok || !pres) begin
                    p_inv = 1'b1;
                end else begin
                    p_wr             = 1'b1;
                    p_flg[FB_SUSP]   = 1'b0;
                end
            end
            MODE_TIMEOUT: begin
                if (r_req.timeout_ticks != 16'd0) begin
                    if ((r_dl == 32'd0) || (abs_dl < r_dl)) begin
                        p_dl_we = 1'b1;
                        p_dl    = abs_dl;
                    end
                    if (r_ten && (r_req.current_thread == r_tt) && c_ok &&
                        r_flg_rd[FB_READY]) begin
                        p_wr = 1'b1;
                        p_wk = w_dec;
                        if (w_dec != 2'd0) begin
                            p_early = 1'b1;
                        end else begin
                            p_flg[FB_READY]   = 1'b0;
                            p_flg[FB_BLOCKED] = 1'b1;
                            p_rem             = 1'b1;
                        end
                    end
                end
            end
            MODE_ACT: begin
                if (!t_ok || !r_flg_rd[FB_EVENT]) begin
                    p_inv = 1'b1;
                end else if (!r_flg_rd[FB_READY] && !r_flg_rd[FB_BLOCKED]) begin
                    p_wr            = 1'b1;
                    p_flg[FB_READY] = 1'b1;
                    p_app           = 1'b1;
                end
            end
            MODE_DEACT: begin
                if (!t_ok) begin
                    p_inv = 1'b1;
                end else if (!pres) begin
                    if (!l_ok) begin
                        p_inv = 1'b1;
                    end else begin
                        p_wr            = 1'b1;
                        p_lvl           = VW'(r_req.priority_req);
                        p_wk            = WAKE_INIT;
                        p_flg           = 4'b0000;
                        p_flg[FB_SUSP]  = r_flg_rd[FB_SUSP];
                        p_flg[FB_EVENT] = 1'b1;
                    end
                end else if (!r_flg_rd[FB_EVENT]) begin
                    p_inv = 1'b1;
                end else begin
                    p_wr              = 1'b1;
                    p_rem             = r_flg_rd[FB_READY];
                    p_flg[FB_READY]   = 1'b0;
                    p_flg[FB_BLOCKED] = 1'b0;
                end
            end
            default: begin
                p_inv = 1'b1;
            end
        endcase
    end

    // memory addresses and write data per command
    always_comb begin
        info_we = 1'b0;
        info_wa = r_t;
        lvl_wd  = p_lvl;
        flg_wd  = p_flg;
        wk_wd   = p_wk;
        nxt_we  = 1'b0;
        nxt_wa  = r_t;
        nxt_wd  = NONE;
        prv_we  = 1'b0;
        prv_wa  = r_t;
        prv_wd  = r_tail_rd;
        head_we = 1'b0;
        head_wa = r_nl;
        head_wd = LW'(r_t);
        tail_we = 1'b0;
        tail_wa = r_nl;
        tail_wd = LW'(r_t);
        info_ra = r_t;
        lv_ra   = r_nl;
        unique case (i_cmd.cmd) inside
            CMD_CLEAR: begin
                info_we = 32'(r_clr) < THREADS;
                info_wa = r_clr[TW-1:0];
                lvl_wd  = '0;
                flg_wd  = 4'b0000;
                wk_wd   = WAKE_INIT;
                head_we = 32'(r_clr) < LEVELS;
                head_wa = r_clr[VW-1:0];
                head_wd = NONE;
                tail_we = 32'(r_clr) < LEVELS;
                tail_wa = r_clr[VW-1:0];
                tail_wd = NONE;
            end
            CMD_EVAL: begin
                info_we = p_wr;
            end
            CMD_REMOVE: begin
                head_wa = r_ol;
                tail_wa = r_ol;
                if (r_p == NONE) begin
                    head_we = 1'b1;
                    head_wd = r_n;
                end else begin
                    nxt_we = 1'b1;
                    nxt_wa = r_p[TW-1:0];
                    nxt_wd = r_n;
                end
                if (r_n == NONE) begin
                    tail_we = 1'b1;
                    tail_wd = r_p;
                end else begin
                    prv_we = 1'b1;
                    prv_wa = r_n[TW-1:0];
                    prv_wd = r_p;
                end
            end
            CMD_APP_WR: begin
                prv_we  = 1'b1;
                tail_we = 1'b1;
                if (r_tail_rd == NONE) begin
                    head_we = 1'b1;
                end else begin
                    nxt_we = 1'b1;
                    nxt_wa = r_tail_rd[TW-1:0];
                    nxt_wd = LW'(r_t);
                end
            end
            CMD_APP_NX: begin
                nxt_we = 1'b1;
            end
            CMD_SA_RD: begin
                info_ra = TW'(r_req.current_thread);
            end
            CMD_SC_STEP: begin
                info_ra = r_c[TW-1:0];
                lv_ra   = r_lv[VW-1:0];
            end
            CMD_NOP, CMD_LATCH, CMD_RD_INFO, CMD_EVAL_MOVE, CMD_APP_RD,
            CMD_SC_INIT_H, CMD_SA_INIT, CMD_SC_HEAD, CMD_SC_CHK, CMD_TAKE,
            CMD_TGT, CMD_OUT_LOAD: begin
            end
            default: begin
            end
        endcase
    end

    // thread memories
    always_ff @(posedge i_clk) begin
        if (info_we) begin
            lvl_mem[info_wa] <= lvl_wd;
            flg_mem[info_wa] <= flg_wd;
            wk_mem[info_wa]  <= wk_wd;
        end
        if (nxt_we) begin
            nxt_mem[nxt_wa] <= nxt_wd;
        end
        if (prv_we) begin
            prv_mem[prv_wa] <= prv_wd;
        end
        r_lvl_rd <= lvl_mem[info_ra];
        r_flg_rd <= flg_mem[info_ra];
        r_wk_rd  <= wk_mem[info_ra];
        r_nxt_rd <= nxt_mem[info_ra];
        r_prv_rd <= prv_mem[info_ra];
    end

    // level head and tail memories
    always_ff @(posedge i_clk) begin
        if (head_we) begin
            head_mem[head_wa] <= head_wd;
        end
        if (tail_we) begin
            tail_mem[tail_wa] <= tail_wd;
        end
        r_head_rd <= head_mem[lv_ra];
        r_tail_rd <= tail_mem[lv_ra];
    end

    // result formatting
    always_comb begin
        n_out = '0;
        n_out.wake_early = r_early;
        if (r_nx == NONE) begin
            n_out.status = r_inv ? STS_INVALID : STS_EMPTY;
        end else begin
            n_out.next_thread = 6'(r_nx);
            n_out.do_switch   = 32'(r_nx) != 32'(r_req.current_thread);
            n_out.status      = r_inv ? STS_INVALID : STS_OK;
        end
    end

    // control registers: clearing counter, tick, deadline, config, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_tick <= 32'd0;
            r_dl   <= 32'd0;
            r_tt   <= 6'd0;
            r_ten  <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (i_cmd.cmd == CMD_CLEAR) begin
                r_clr <= r_clr + CW'(1);
            end
            if ((i_cmd.cmd == CMD_LATCH) && (i_in_data.mode == MODE_TICK)) begin
                r_tick <= r_tick + 32'd1;
            end
            if ((i_cmd.cmd == CMD_EVAL) && p_dl_we) begin
                r_dl <= p_dl;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_TIMEOUT_THREAD: r_tt  <= i_cfg_data;
                    CFG_TIMEOUT_ENABLE: r_ten <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.cmd == CMD_OUT_LOAD) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // working registers per command
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.cmd) inside
            CMD_LATCH: begin
                r_req <= i_in_data;
                case (i_in_data.mode) inside
                    MODE_BLOCK, MODE_TIMEOUT: r_t <= TW'(i_in_data.current_thread);
                    MODE_TICK:                r_t <= TW'(r_tt);
                    default:                  r_t <= TW'(i_in_data.thread_id);
                endcase
            end
            CMD_EVAL: begin
                r_rem   <= p_rem;
                r_app   <= p_app;
                r_ol    <= r_lvl_rd;
                r_nl    <= p_nl;
                r_p     <= r_prv_rd;
                r_n     <= r_nxt_rd;
                r_inv   <= p_inv;
                r_early <= p_early;
            end
            CMD_EVAL_MOVE: begin
                r_rem <= 1'b1;
                r_app <= 1'b1;
                r_ol  <= r_lvl_rd;
                r_nl  <= r_lvl_rd;
                r_p   <= r_prv_rd;
                r_n   <= r_nxt_rd;
            end
            CMD_SC_INIT_H: begin
                r_c     <= NONE;
                r_lv    <= '0;
                r_found <= NONE;
            end
            CMD_SA_INIT: begin
                r_c     <= r_nxt_rd;
                r_lv    <= LVW'(r_lvl_rd) + LVW'(1);
                r_found <= NONE;
            end
            CMD_SC_STEP: begin
                if ((r_c == NONE) && (r_lv != LVW'(LEVELS))) begin
                    r_lv <= r_lv + LVW'(1);
                end
            end
            CMD_SC_HEAD: begin
                r_c <= r_head_rd;
            end
            CMD_SC_CHK: begin
                if (!r_flg_rd[FB_SUSP]) begin
                    r_found <= r_c;
                end else begin
                    r_c <= r_nxt_rd;
                end
            end
            CMD_TAKE: begin
                r_nx <= r_found;
                r_t  <= r_found[TW-1:0];
            end
            CMD_TGT: begin
                r_t <= r_found[TW-1:0];
            end
            CMD_OUT_LOAD: begin
                r_out <= n_out;
            end
            CMD_NOP, CMD_CLEAR, CMD_RD_INFO, CMD_REMOVE, CMD_APP_RD, CMD_APP_WR,
            CMD_APP_NX, CMD_SA_RD: begin
            end
            default: begin
            end
        endcase
    end

    // status toward the controller
    always_comb begin
        o_st            = '0;
        o_st.clr_done   = r_clr == CW'(MAXD - 1);
        o_st.mode       = r_req.mode;
        o_st.rem        = r_rem;
        o_st.app        = r_app;
        o_st.c_none     = r_c == NONE;
        o_st.lv_end     = r_lv == LVW'(LEVELS);
        o_st.rd_susp    = r_flg_rd[FB_SUSP];
        o_st.found_none = r_found == NONE;
        o_st.found_cur  = 32'(r_found) == 32'(r_req.current_thread);
        o_st.out_free   = !r_ov || !i_out_stall;
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

endmodule

[design/fpsched_ctrl.sv]
// ----------------------------------------------------------------------------
// fpsched_ctrl
// Scheduler sequencer: walks each request through record read, evaluation,
// list unlink/relink, level scans and the round-robin rotation, issuing one
// datapath command per cycle.
// ----------------------------------------------------------------------------
module fpsched_ctrl
    import fpsched_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_st,
    output t_dp_cmd    o_cmd,
    output logic       o_in_stall
);

    t_state r_state;
    t_state n_state;
    t_phase r_phase;
    t_phase n_phase;
    logic   rot_mode;

    assign rot_mode = (i_st.mode == MODE_YIELD) || (i_st.mode == MODE_TICK);

    // state and phase registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_phase <= PH_MAIN;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    // next state and commands
    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        o_cmd.cmd = CMD_NOP;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.cmd = CMD_CLEAR;
                if (i_st.clr_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cmd = CMD_LATCH;
                    n_phase   = PH_MAIN;
                    n_state   = ST_RD_INFO;
                end
            end
            ST_RD_INFO: begin
                o_cmd.cmd = CMD_RD_INFO;
                n_state   = ST_EVAL;
            end
            ST_EVAL: begin
                o_cmd.cmd = (r_phase == PH_MOVE) ? CMD_EVAL_MOVE : CMD_EVAL;
                n_state   = ST_REMOVE;
            end
            ST_REMOVE: begin
                if (i_st.rem) begin
                    o_cmd.cmd = CMD_REMOVE;
                end
                n_state = i_st.app ? ST_APP_RD : ST_OP_DONE;
            end
            ST_APP_RD: begin
                o_cmd.cmd = CMD_APP_RD;
                n_state   = ST_APP_WR;
            end
            ST_APP_WR: begin
                o_cmd.cmd = CMD_APP_WR;
                n_state   = ST_APP_NX;
            end
            ST_APP_NX: begin
                o_cmd.cmd = CMD_APP_NX;
                n_state   = ST_OP_DONE;
            end
            // choose the scan that follows the list edits
            ST_OP_DONE: begin
                if ((r_phase == PH_MOVE) && (i_st.mode == MODE_TICK)) begin
                    n_phase = PH_S2;
                    n_state = ST_SA_RD;
                end else begin
                    o_cmd.cmd = CMD_SC_INIT_H;
                    n_state   = ST_SC_STEP;
                    if ((r_phase == PH_MAIN) && rot_mode) begin
                        n_phase = PH_H1;
                    end else begin
                        n_phase = PH_FIN;
                    end
                end
            end
            ST_SA_RD: begin
                o_cmd.cmd = CMD_SA_RD;
                n_state   = ST_SA_INIT;
            end
            ST_SA_INIT: begin
                o_cmd.cmd = CMD_SA_INIT;
                n_state   = ST_SC_STEP;
            end
            // scan: next list entry, else head of the next level
            ST_SC_STEP: begin
                o_cmd.cmd = CMD_SC_STEP;
                if (!i_st.c_none) begin
                    n_state = ST_SC_CHK;
                end else if (i_st.lv_end) begin
                    n_state = ST_SC_END;
                end else begin
                    n_state = ST_SC_HEAD;
                end
            end
            ST_SC_HEAD: begin
                o_cmd.cmd = CMD_SC_HEAD;
                n_state   = ST_SC_STEP;
            end
            ST_SC_CHK: begin
                o_cmd.cmd = CMD_SC_CHK;
                n_state   = i_st.rd_susp ? ST_SC_STEP : ST_SC_END;
            end
            // act on the scan result
            ST_SC_END: begin
                n_state = ST_DONE;
                case (r_phase)
                    PH_H1: begin
                        o_cmd.cmd = CMD_TAKE;
                        if (!i_st.found_none && i_st.found_cur) begin
                            if (i_st.mode == MODE_YIELD) begin
                                n_phase = PH_MOVE;
                                n_state = ST_RD_INFO;
                            end else begin
                                n_phase = PH_S1;
                                n_state = ST_SA_RD;
                            end
                        end
                    end
                    PH_S1: begin
                        if (!i_st.found_none) begin
                            o_cmd.cmd = CMD_TGT;
                            n_phase   = PH_MOVE;
                            n_state   = ST_RD_INFO;
                        end
                    end
                    default: begin
                        o_cmd.cmd = CMD_TAKE;
                    end
                endcase
            end
            ST_DONE: begin
                if (i_st.out_free) begin
                    o_cmd.cmd = CMD_OUT_LOAD;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall = r_state != ST_IDLE;

endmodule

[design/fixed_priority_rr_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// fixed_priority_rr_scheduler_unit
// Fixed-priority round-robin run-queue scheduler, one result per request.
// ----------------------------------------------------------------------------
// One request is in work at a time. After reset the unit sweeps its thread
// and level memories, all max(THREADS, LEVELS) addresses, with the input
// stalled. A request then goes through record read, evaluation and list
// relinking, plus one scan for the most urgent runnable thread that steps
// through each level and each list entry it visits; a yield or a tick that
// rotates runs up to three scans. The single read port of each memory sets
// this pace. A finished result sits in an output register, so the next
// request is taken while it waits.
module fixed_priority_rr_scheduler_unit
    import fpsched_pkg::*;
#(
    parameter int THREADS = 64,
    parameter int LEVELS  = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  t_in_item              i_in_data,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output t_out_item             o_out_data,
    input  logic                  i_out_stall,
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd    cmd;
    t_dp_status st;

    // sequencer
    fpsched_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_st       (st),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // memories and arithmetic
    fpsched_dp #(
        .THREADS (THREADS),
        .LEVELS  (LEVELS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_st        (st),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

[design/fpsched_checker.sv]
// ----------------------------------------------------------------------------
// fpsched_checker
// Port-level checks of the scheduler: output hold under stall, one request in
// work at a time, and consistency of the result fields.
// ----------------------------------------------------------------------------
module fpsched_checker
    import fpsched_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input t_out_item o_out_data,
    input logic      i_out_stall
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result changed while stalled");

    // a transfer in closes the input until that request is done
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second request taken while one is in work");

    // no runnable thread reports thread zero and no switch
    a_empty_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == STS_EMPTY)) |->
        ((o_out_data.next_thread == 6'd0) && !o_out_data.do_switch))
        else $error("empty result with thread or switch set");

    // an absorbed block only comes with a valid request
    a_early_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.wake_early) |->
        ((o_out_data.status == STS_OK) || (o_out_data.status == STS_EMPTY)))
        else $error("early wake on an invalid request");

endmodule

bind fixed_priority_rr_scheduler_unit fpsched_checker u_fpsched_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the run-queue scheduler: a directed request list
// and random request streams under several timeout settings. A local model
// of the level lists and thread flags predicts every result, and a monitor
// compares each result transfer, field by field, with that prediction.
// ----------------------------------------------------------------------------
module tb;
    import fpsched_pkg::*;

    localparam int NTHR     = 64;
    localparam int NLVL     = 32;
    localparam int NONE     = NTHR;
    localparam int WDOG_MAX = 20000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    t_in_item              i_in_data = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_item             o_out_data;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [0:0]            i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    fixed_priority_rr_scheduler_unit dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // model state of the run queues
    logic [4:0]  thr_lvl [NTHR];
    logic [3:0]  thr_flg [NTHR];
    logic [1:0]  thr_wake[NTHR];
    int          lnk_nxt [NTHR];
    int          lnk_prv [NTHR];
    int          lvl_hd  [NLVL];
    int          lvl_tl  [NLVL];
    logic [31:0] tick_cnt;
    logic [31:0] deadline;
    logic [5:0]  to_thread;
    logic        to_enable;

    t_in_item  req_q[$];
    t_out_item sched_q[$];
    int        n_req, n_res, n_err, n_fire, idle_cyc;
    int        last_next;
    bit        quiet;
    int        gap_in, gap_out;

    function automatic bit present(int t);
        return thr_flg[t][FB_READY] | thr_flg[t][FB_BLOCKED] | thr_flg[t][FB_EVENT];
    endfunction

    function automatic void list_append(int t);
        int l;
        l = thr_lvl[t];
        lnk_nxt[t] = NONE;
        lnk_prv[t] = lvl_tl[l];
        if (lvl_tl[l] == NONE) lvl_hd[l] = t;
        else lnk_nxt[lvl_tl[l]] = t;
        lvl_tl[l] = t;
    endfunction

    function automatic void list_unlink(int t);
        int l, p, n;
        l = thr_lvl[t];
        p = lnk_prv[t];
        n = lnk_nxt[t];
        if (p == NONE) lvl_hd[l] = n;
        else lnk_nxt[p] = n;
        if (n == NONE) lvl_tl[l] = p;
        else lnk_prv[n] = p;
    endfunction

    function automatic int first_runnable(int t);
        while (t != NONE) begin
            if (!thr_flg[t][FB_SUSP]) return t;
            t = lnk_nxt[t];
        end
        return NONE;
    endfunction

    function automatic int most_urgent();
        int r;
        for (int l = 0; l < NLVL; l++) begin
            r = first_runnable(lvl_hd[l]);
            if (r != NONE) return r;
        end
        return NONE;
    endfunction

    function automatic int runner_up(int h);
        int r;
        r = first_runnable(lnk_nxt[h]);
        if (r != NONE) return r;
        for (int l = thr_lvl[h] + 1; l < NLVL; l++) begin
            r = first_runnable(lvl_hd[l]);
            if (r != NONE) return r;
        end
        return NONE;
    endfunction

    function automatic void set_ready(int t);
        thr_flg[t][FB_READY] = 1'b1;
        thr_flg[t][FB_BLOCKED] = 1'b0;
        list_append(t);
    endfunction

    // returns one when a pending wake absorbs the block
    function automatic bit block_thread(int t);
        if (thr_wake[t] != 0) thr_wake[t]--;
        if (thr_wake[t] != 0) return 1'b1;
        thr_flg[t][FB_READY] = 1'b0;
        thr_flg[t][FB_BLOCKED] = 1'b1;
        list_unlink(t);
        return 1'b0;
    endfunction

    function automatic void wake_thread(int t);
        if (thr_wake[t] != WAKE_MAX) thr_wake[t]++;
        if (thr_flg[t][FB_BLOCKED]) set_ready(t);
    endfunction

    function automatic void sched_reset();
        for (int i = 0; i < NTHR; i++) begin
            thr_lvl[i] = '0;
            thr_flg[i] = '0;
            thr_wake[i] = WAKE_INIT;
            lnk_nxt[i] = 0;
            lnk_prv[i] = 0;
        end
        for (int i = 0; i < NLVL; i++) begin
            lvl_hd[i] = NONE;
            lvl_tl[i] = NONE;
        end
        tick_cnt = '0;
        deadline = '0;
        to_thread = '0;
        to_enable = 1'b0;
    endfunction

    // apply one request to the model and return the scheduling decision
    function automatic t_out_item sched_decide(t_in_item rq);
        t_out_item   res;
        int          tid, cur, nx, s;
        logic [1:0]  sts;
        bit          early, rot;
        logic [31:0] abs_t;
        tid = rq.thread_id;
        cur = rq.current_thread;
        sts = STS_OK;
        early = 1'b0;
        rot = 1'b0;
        nx = NONE;
        case (rq.mode)
            MODE_ADD: begin
                if (present(tid)) sts = STS_INVALID;
                else begin
                    thr_lvl[tid] = rq.priority_req;
                    thr_wake[tid] = WAKE_INIT;
                    thr_flg[tid] = '0;
                    thr_flg[tid][FB_READY] = 1'b1;
                    list_append(tid);
                end
            end
            MODE_SETPRIO: begin
                if (!present(tid)) sts = STS_INVALID;
                else if (thr_flg[tid][FB_READY]) begin
                    list_unlink(tid);
                    thr_lvl[tid] = rq.priority_req;
                    list_append(tid);
                end else thr_lvl[tid] = rq.priority_req;
            end
            MODE_BLOCK: begin
                if (!thr_flg[cur][FB_READY]) sts = STS_INVALID;
                else early = block_thread(cur);
            end
            MODE_WAKE: begin
                if (!present(tid)) sts = STS_INVALID;
                else wake_thread(tid);
            end
            MODE_YIELD: begin
                s = most_urgent();
                if (s != NONE && s == cur) begin
                    list_unlink(s);
                    list_append(s);
                end
            end
            MODE_TICK: begin
                tick_cnt++;
                if (to_enable && deadline != 0 && tick_cnt == deadline) begin
                    deadline = '0;
                    n_fire++;
                    if (present(to_thread)) wake_thread(to_thread);
                end
                nx = most_urgent();
                if (nx != NONE && nx == cur) begin
                    s = runner_up(nx);
                    if (s != NONE) begin
                        list_unlink(s);
                        list_append(s);
                        nx = runner_up(cur);
                    end
                end
                rot = 1'b1;
            end
            MODE_SUSPEND: begin
                if (!present(tid)) sts = STS_INVALID;
                else thr_flg[tid][FB_SUSP] = 1'b1;
            end
            MODE_RESUME: begin
                if (!present(tid)) sts = STS_INVALID;
                else thr_flg[tid][FB_SUSP] = 1'b0;
            end
            MODE_TIMEOUT: begin
                if (rq.timeout_ticks != 0) begin
                    abs_t = tick_cnt + 32'(rq.timeout_ticks);
                    if (deadline == 0 || abs_t < deadline) deadline = abs_t;
                    if (to_enable && cur == to_thread && thr_flg[cur][FB_READY])
                        early = block_thread(cur);
                end
            end
            MODE_ACT: begin
                if (!thr_flg[tid][FB_EVENT]) sts = STS_INVALID;
                else if (!thr_flg[tid][FB_READY] && !thr_flg[tid][FB_BLOCKED])
                    set_ready(tid);
            end
            MODE_DEACT: begin
                if (!present(tid)) begin
                    thr_lvl[tid] = rq.priority_req;
                    thr_wake[tid] = WAKE_INIT;
                    thr_flg[tid][FB_EVENT] = 1'b1;
                end else if (!thr_flg[tid][FB_EVENT]) sts = STS_INVALID;
                else begin
                    if (thr_flg[tid][FB_READY]) list_unlink(tid);
                    thr_flg[tid][FB_READY] = 1'b0;
                    thr_flg[tid][FB_BLOCKED] = 1'b0;
                end
            end
            default: sts = STS_INVALID;
        endcase
        if (!rot) nx = most_urgent();
        if (nx == NONE) begin
            res.next_thread = '0;
            res.do_switch = 1'b0;
            if (sts == STS_OK) sts = STS_EMPTY;
        end else begin
            res.next_thread = 6'(nx);
            res.do_switch = (nx != cur);
        end
        res.status = sts;
        res.wake_early = early;
        last_next = res.next_thread;
        return res;
    endfunction

    // idle lengths: mostly short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // input side driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!(i_in_valid && o_in_stall)) begin
            if (i_in_valid) begin
                sched_q.push_back(sched_decide(i_in_data));
                n_req++;
            end
            if (gap_in != 0) begin
                gap_in--;
                i_in_valid <= 1'b0;
            end else if (req_q.size() != 0) begin
                i_in_data <= req_q.pop_front();
                i_in_valid <= 1'b1;
                gap_in = quiet ? 0 : idle_len();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result side monitor and stall generator
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                n_res++;
                if (sched_q.size() == 0) begin
                    n_err++;
                    if (n_err <= 10) $display("unexpected result transfer %p", o_out_data);
                end else begin
                    t_out_item want;
                    want = sched_q.pop_front();
                    if (want.next_thread !== o_out_data.next_thread ||
                        want.do_switch !== o_out_data.do_switch ||
                        want.status !== o_out_data.status ||
                        want.wake_early !== o_out_data.wake_early) begin
                        n_err++;
                        if (n_err <= 10)
                            $display("result %0d mismatch: expected %p, got %p",
                                     n_res, want, o_out_data);
                    end
                end
            end
            if (gap_out != 0) begin
                gap_out--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                gap_out = quiet ? 0 : idle_len();
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) idle_cyc = 0;
        else idle_cyc++;
        if (idle_cyc >= WDOG_MAX) begin
            $display("watchdog expired after %0d idle cycles", idle_cyc);
            $display("tb NOT OK");
            $finish;
        end
    end

    function automatic t_in_item mk_req(t_mode m, int tid, int pr, int cur, int tk);
        t_in_item r;
        r.mode = m;
        r.thread_id = 6'(tid);
        r.priority_req = 5'(pr);
        r.current_thread = 6'(cur);
        r.timeout_ticks = 16'(tk);
        return r;
    endfunction

    function automatic int pick_thread();
        if ($urandom_range(0, 99) < 80) return $urandom_range(0, 9);
        return $urandom_range(0, 63);
    endfunction

    // random request, weighted toward live threads and the running one
    function automatic t_in_item rand_req();
        t_in_item r;
        int       w;
        w = $urandom_range(0, 99);
        r.mode = (w < 12) ? MODE_ADD : (w < 18) ? MODE_SETPRIO : (w < 30) ? MODE_BLOCK :
                 (w < 42) ? MODE_WAKE : (w < 48) ? MODE_YIELD : (w < 66) ? MODE_TICK :
                 (w < 71) ? MODE_SUSPEND : (w < 77) ? MODE_RESUME :
                 (w < 85) ? MODE_TIMEOUT : (w < 90) ? MODE_ACT :
                 (w < 95) ? MODE_DEACT : 4'($urandom_range(0, 15));
        r.thread_id = 6'(pick_thread());
        r.priority_req = ($urandom_range(0, 3) != 0) ? 5'($urandom_range(0, 3))
                                                     : 5'($urandom_range(0, 31));
        r.current_thread = ($urandom_range(0, 99) < 65) ? 6'(last_next) : 6'(pick_thread());
        w = $urandom_range(0, 9);
        r.timeout_ticks = (w < 6) ? 16'($urandom_range(1, 20)) :
                          (w < 7) ? 16'd0 : (w < 8) ? 16'hffff : 16'($urandom);
        return r;
    endfunction

    task automatic cfg_write(logic [0:0] idx, int val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= CFG_DATA_W'(val);
        if (idx == CFG_TIMEOUT_THREAD) to_thread = 6'(val);
        else to_enable = val[0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (req_q.size() != 0 || i_in_valid || sched_q.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    initial begin
        int tt_val[4];
        int en_val[4];
        sched_reset();
        n_req = 0; n_res = 0; n_err = 0; n_fire = 0; idle_cyc = 0;
        last_next = 0; quiet = 0; gap_in = 0; gap_out = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed requests, thread 3 registered as timeout thread
        cfg_write(CFG_TIMEOUT_THREAD, 3);
        cfg_write(CFG_TIMEOUT_ENABLE, 1);
        req_q.push_back(mk_req(MODE_TICK,     0,  0,  0, 0));
        req_q.push_back(mk_req(MODE_ADD,      0,  0,  0, 0));
        req_q.push_back(mk_req(MODE_ADD,     63, 31,  0, 0));
        req_q.push_back(mk_req(MODE_ADD,      0,  5,  0, 0));
        req_q.push_back(mk_req(MODE_ADD,      3,  0,  0, 0));
        req_q.push_back(mk_req(MODE_YIELD,    0,  0,  0, 0));
        req_q.push_back(mk_req(MODE_TICK,     0,  0,  3, 0));
        req_q.push_back(mk_req(MODE_BLOCK,    0,  0,  0, 0));
        req_q.push_back(mk_req(MODE_SETPRIO,  0,  7,  3, 0));
        req_q.push_back(mk_req(MODE_WAKE,     0,  0,  3, 0));
        req_q.push_back(mk_req(MODE_WAKE,     0,  0,  3, 0));
        req_q.push_back(mk_req(MODE_BLOCK,    0,  0,  0, 0));
        req_q.push_back(mk_req(MODE_SETPRIO, 63,  0,  3, 0));
        req_q.push_back(mk_req(MODE_SUSPEND,  3,  0,  3, 0));
        req_q.push_back(mk_req(MODE_RESUME,   3,  0,  3, 0));
        req_q.push_back(mk_req(MODE_TIMEOUT,  0,  0,  3, 2));
        req_q.push_back(mk_req(MODE_TICK,     0,  0, 63, 0));
        req_q.push_back(mk_req(MODE_TICK,     0,  0, 63, 0));
        req_q.push_back(mk_req(MODE_DEACT,   10, 31,  0, 0));
        req_q.push_back(mk_req(MODE_ACT,     10,  0,  0, 0));
        req_q.push_back(mk_req(MODE_DEACT,   10,  0,  0, 0));
        req_q.push_back(mk_req(MODE_DEACT,    0,  0,  0, 0));
        req_q.push_back(mk_req(MODE_ACT,      0,  0,  0, 0));
        req_q.push_back(mk_req(MODE_WAKE,    20,  0,  0, 0));
        req_q.push_back(mk_req(t_mode'(4'hf), 63, 31, 63, 16'hffff));
        req_q.push_back(mk_req(MODE_TIMEOUT, 63, 31, 63, 16'hffff));
        drain();

        // random phases under several timeout settings
        tt_val = '{63, 0, 5, 0};
        en_val = '{1, 0, 1, 1};
        for (int ph = 0; ph < 4; ph++) begin
            if (ph == 2) tt_val[ph] = $urandom_range(0, 9);
            cfg_write(CFG_TIMEOUT_THREAD, tt_val[ph]);
            cfg_write(CFG_TIMEOUT_ENABLE, en_val[ph]);
            quiet = (ph == 1);
            for (int n = 0; n < 310; n++) begin
                while (req_q.size() >= 2) @(posedge i_clk);
                req_q.push_back(rand_req());
            end
            drain();
        end
        repeat (20) @(posedge i_clk);

        $display("requests sent %0d, results checked %0d, mismatches %0d", n_req, n_res, n_err);
        $display("timeout deadlines reached %0d over 5 timeout settings", n_fire);
        if (n_err == 0 && sched_q.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

[sim.f]
design/fpsched_pkg.sv
design/fpsched_dp.sv
design/fpsched_ctrl.sv
design/fixed_priority_rr_scheduler_unit.sv
design/fpsched_checker.sv
tb/sv/tb.sv
